[src/assert_macros.svh]
// assertion macros used by the port checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: same-cycle rule");

// antecedent implies consequent in the next cycle
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle rule");

`endif

[src/rrwt_pkg.sv]
// types, constants and helpers of the receive window tracker
package rrwt_pkg;

  localparam int WIN_BITS = 32;
  localparam int SEQ_W    = 32;
  localparam int CNT_W    = 16;
  localparam int ADV_W    = 6;
  localparam int IDX_W    = 5;

  localparam logic [CNT_W-1:0] THRESH_RESET = 16'd16;
  localparam logic [CNT_W-1:0] CNT_MAX      = 16'hFFFF;
  localparam logic [ADV_W-1:0] ADV_FULL     = 6'd32;

  // configuration register indexes
  localparam logic [1:0] CFG_ORDERED_MODE = 2'd0;
  localparam logic [1:0] CFG_ACK_THRESH   = 2'd1;
  localparam logic [1:0] CFG_INIT_SEQ     = 2'd2;

  typedef enum logic [2:0] {
    V_IN_ORDER     = 3'd0,
    V_OUT_OF_ORDER = 3'd1,
    V_TOO_EARLY    = 3'd2,
    V_DUPLICATE    = 3'd3,
    V_NO_SLOT      = 3'd4,
    V_SNAPSHOT     = 3'd5
  } verdict_t;

  typedef enum logic {
    KIND_MSG  = 1'b0,
    KIND_SNAP = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic              slot_free;
  } item_t;

  typedef struct packed {
    logic              ordered_mode;
    logic [CNT_W-1:0]  threshold;
    logic              load;
    logic [SEQ_W-1:0]  load_seq;
  } cfg_t;

  typedef struct packed {
    verdict_t             verdict;
    logic                 defer_delivery;
    logic [ADV_W-1:0]     newly_complete;
    logic                 ack_now;
    logic                 ack_later;
    logic [SEQ_W-1:0]     ack_seqnum;
    logic [WIN_BITS-1:0]  ack_bitmap;
    logic                 ack_was_pending;
  } result_t;

  // number of set bits at the bottom of v, 32 when all are set
  function automatic logic [ADV_W-1:0] trailing_ones(input logic [WIN_BITS-1:0] v);
    logic [ADV_W-1:0] n;
    n = ADV_FULL;
    for (int i = WIN_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        n = ADV_W'(i);
      end
    end
    return n;
  endfunction

endpackage

[src/rrwt_front.sv]
// input stage: takes items from the stream and decodes their kind
module rrwt_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_opcode,
  input  logic [rrwt_pkg::SEQ_W-1:0] in_seq,
  input  logic                      in_slot_free,
  output logic                      push,
  output rrwt_pkg::item_t           push_item,
  input  logic                      q_ready
);

  logic            valid_r, valid_nxt;
  rrwt_pkg::item_t item_r;
  logic            in_fire;

  assign push      = valid_r && q_ready;
  assign push_item = item_r;
  assign in_ready  = !valid_r || q_ready;
  assign in_fire   = in_valid && in_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (push) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_r.kind      <= in_opcode ? rrwt_pkg::KIND_SNAP : rrwt_pkg::KIND_MSG;
      item_r.seq       <= in_seq;
      item_r.slot_free <= in_slot_free;
    end
  end

endmodule

[src/rrwt_queue.sv]
// two-entry queue between the input stage and the window engine
module rrwt_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rrwt_pkg::item_t push_item,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output rrwt_pkg::item_t head_item
);

  rrwt_pkg::item_t mem_r [2];
  logic            wr_ptr_r, wr_ptr_nxt;
  logic            rd_ptr_r, rd_ptr_nxt;
  logic [1:0]      count_r, count_nxt;

  assign q_ready   = (count_r != 2'd2);
  assign q_valid   = (count_r != 2'd0);
  assign head_item = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

[src/rrwt_back.sv]
// window engine: classifies against the window, updates it and holds the result
module rrwt_back (
  input  logic              clk,
  input  logic              rst_n,
  input  rrwt_pkg::cfg_t    cfg,
  input  logic              q_valid,
  input  rrwt_pkg::item_t   head_item,
  output logic              pop,
  output logic              res_valid,
  input  logic              res_ready,
  output rrwt_pkg::result_t res
);

  logic [rrwt_pkg::SEQ_W-1:0]    last_r, last_nxt;
  logic [rrwt_pkg::WIN_BITS-1:0] bitmap_r, bitmap_nxt;
  logic [rrwt_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                          forced_r, forced_nxt;
  logic                          out_valid_r, out_valid_nxt;
  rrwt_pkg::result_t             res_r, res_nxt;

  logic [rrwt_pkg::SEQ_W-1:0]    rel;
  logic                          in_win;
  logic [rrwt_pkg::IDX_W-1:0]    idx;
  logic                          dup_bit;
  logic [rrwt_pkg::WIN_BITS-1:0] set_bm;
  logic                          all_ones;
  logic [rrwt_pkg::ADV_W-1:0]    tone;
  logic [rrwt_pkg::ADV_W-1:0]    adv;
  logic [rrwt_pkg::CNT_W:0]      cnt_sum;
  logic [rrwt_pkg::CNT_W-1:0]    cnt_sat;
  logic                          force_imm;
  logic                          force_del;

  assign pop       = q_valid && (!out_valid_r || res_ready);
  assign res_valid = out_valid_r;
  assign res       = res_r;

  // window arithmetic for the item at the head of the queue
  always_comb begin
    rel      = head_item.seq - last_r - 32'd1;
    in_win   = (rel[rrwt_pkg::SEQ_W-1:rrwt_pkg::IDX_W] == '0);
    idx      = rel[rrwt_pkg::IDX_W-1:0];
    dup_bit  = bitmap_r[idx];
    set_bm   = bitmap_r | (32'd1 << idx);
    all_ones = &set_bm;
    tone     = rrwt_pkg::trailing_ones(set_bm);
    adv      = all_ones ? rrwt_pkg::ADV_FULL : tone;
    cnt_sum  = {1'b0, cnt_r} + 17'(adv);
    cnt_sat  = cnt_sum[rrwt_pkg::CNT_W] ? rrwt_pkg::CNT_MAX : cnt_sum[rrwt_pkg::CNT_W-1:0];
    // every eighth position ahead forces an immediate ack
    force_imm = in_win && !dup_bit && (idx != '0) && (idx[2:0] == 3'd0);
    force_del = !in_win || dup_bit;
  end

  always_comb begin
    last_nxt      = last_r;
    bitmap_nxt    = bitmap_r;
    cnt_nxt       = cnt_r;
    forced_nxt    = forced_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    if (res_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      unique case (head_item.kind)
        rrwt_pkg::KIND_SNAP: begin
          res_nxt.verdict         = rrwt_pkg::V_SNAPSHOT;
          res_nxt.ack_seqnum      = last_r;
          res_nxt.ack_bitmap      = bitmap_r;
          res_nxt.ack_was_pending = (cnt_r != '0) || forced_r;
          cnt_nxt                 = '0;
          forced_nxt              = 1'b0;
        end
        rrwt_pkg::KIND_MSG: begin
          if (force_del) begin
            res_nxt.verdict   = (!in_win && !rel[rrwt_pkg::SEQ_W-1]) ?
                                rrwt_pkg::V_TOO_EARLY : rrwt_pkg::V_DUPLICATE;
            forced_nxt        = 1'b1;
            res_nxt.ack_now   = (cnt_r >= cfg.threshold);
            res_nxt.ack_later = !(cnt_r >= cfg.threshold);
          end else if (!head_item.slot_free) begin
            res_nxt.verdict = rrwt_pkg::V_NO_SLOT;
          end else begin
            res_nxt.verdict        = (idx == '0) ? rrwt_pkg::V_IN_ORDER :
                                                   rrwt_pkg::V_OUT_OF_ORDER;
            res_nxt.defer_delivery = (idx != '0) && cfg.ordered_mode;
            res_nxt.newly_complete = adv;
            bitmap_nxt             = all_ones ? '0 : (set_bm >> tone[rrwt_pkg::IDX_W-1:0]);
            last_nxt               = last_r + 32'(adv);
            cnt_nxt                = cnt_sat;
            if (force_imm) begin
              forced_nxt = 1'b1;
            end
            res_nxt.ack_now   = (cnt_sat >= cfg.threshold) || force_imm;
            res_nxt.ack_later = !res_nxt.ack_now && (adv != '0);
          end
        end
        default: begin
          res_nxt = '0;
        end
      endcase
    end
    // a new connection start reloads the window
    if (cfg.load) begin
      last_nxt   = cfg.load_seq;
      bitmap_nxt = '0;
      cnt_nxt    = '0;
      forced_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r      <= '0;
      bitmap_r    <= '0;
      cnt_r       <= '0;
      forced_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      last_r      <= last_nxt;
      bitmap_r    <= bitmap_nxt;
      cnt_r       <= cnt_nxt;
      forced_r    <= forced_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

endmodule

[src/reliable_receive_window_tracker.sv]
// top level of the reliable-link receive window tracker
//
// in_ channel: one item per handshake, in_tuser is the opcode (0 received
// message, 1 take ack snapshot); in_tdata carries the sequence number and the
// event slot flag. out_ channel: exactly one result item per input item, in
// order; out_tuser is the verdict, out_tdata the ack fields.
// cfg_ channel: register writes (0 ordered mode, 1 ack threshold, 2 initial
// sequence number, which also restarts the window); always ready.
// an item passes the input register, the queue and the result register on its
// way to result valid. throughput: one item per cycle while out_tready stays
// high, set by the single window update (subtract, priority encode of the
// trailing run, shift) in the engine.
// reset: window at sequence 0, empty bitmap, nothing pending, threshold 16.
// when out_tready is low the result register holds; the two-entry queue and
// input register fill up behind it, then in_tready drops.
module reliable_receive_window_tracker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // seq_num[31:0], event_slot_free[32], zero pad
  input  logic        in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // defer_delivery[0], newly_complete[6:1],
                                  // ack_now[7], ack_later[8], ack_seqnum[40:9],
                                  // ack_bitmap[72:41], ack_was_pending[73], zero pad
  output logic [2:0]  out_tuser,  // verdict
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic                           ordered_r, ordered_nxt;
  logic [rrwt_pkg::CNT_W-1:0]     thresh_r, thresh_nxt;
  logic                           cfg_fire;
  rrwt_pkg::cfg_t                 cfg;
  logic                           push, q_ready, pop, q_valid;
  rrwt_pkg::item_t                push_item, head_item;
  rrwt_pkg::result_t              res;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;

  always_comb begin
    ordered_nxt = ordered_r;
    thresh_nxt  = thresh_r;
    if (cfg_fire && (cfg_index == rrwt_pkg::CFG_ORDERED_MODE)) begin
      ordered_nxt = cfg_data[0];
    end
    if (cfg_fire && (cfg_index == rrwt_pkg::CFG_ACK_THRESH)) begin
      thresh_nxt = cfg_data[rrwt_pkg::CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ordered_r <= 1'b0;
      thresh_r  <= rrwt_pkg::THRESH_RESET;
    end else begin
      ordered_r <= ordered_nxt;
      thresh_r  <= thresh_nxt;
    end
  end

  assign cfg.ordered_mode = ordered_r;
  assign cfg.threshold    = thresh_r;
  assign cfg.load         = cfg_fire && (cfg_index == rrwt_pkg::CFG_INIT_SEQ);
  assign cfg.load_seq     = cfg_data;

  rrwt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .in_opcode    (in_tuser),
    .in_seq       (in_tdata[31:0]),
    .in_slot_free (in_tdata[32]),
    .push         (push),
    .push_item    (push_item),
    .q_ready      (q_ready)
  );

  rrwt_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .q_ready   (q_ready),
    .pop       (pop),
    .q_valid   (q_valid),
    .head_item (head_item)
  );

  rrwt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .q_valid   (q_valid),
    .head_item (head_item),
    .pop       (pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tuser = res.verdict;
  assign out_tdata = {6'd0, res.ack_was_pending, res.ack_bitmap, res.ack_seqnum,
                      res.ack_later, res.ack_now, res.newly_complete,
                      res.defer_delivery};

endmodule

[src/rrwt_checker.sv]
// port-level checks for the receive window tracker, bound to the top level
`include "assert_macros.svh"

module rrwt_port_checks (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [79:0] out_tdata,
  input logic [2:0]  out_tuser
);

  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable({out_tuser, out_tdata}))
  `CHK_SAME(a_ack_excl, out_tvalid, !(out_tdata[7] && out_tdata[8]))
  `CHK_SAME(a_adv_range, out_tvalid, out_tdata[6:1] <= 6'd32)
  `CHK_SAME(a_noslot_zero, out_tvalid && (out_tuser == rrwt_pkg::V_NO_SLOT), out_tdata == '0)

endmodule

bind reliable_receive_window_tracker rrwt_port_checks u_rrwt_port_checks (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
